>>> src/histogram_2d_inverse_cdf_sampler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 2D inverse-CDF sampler
// Shared property templates, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_2D_INVERSE_CDF_SAMPLER_MACROS_SVH
`define HISTOGRAM_2D_INVERSE_CDF_SAMPLER_MACROS_SVH

// same-cycle implication
`define HCDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcdf assertion failed");

// next-cycle implication
`define HCDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcdf assertion failed");

`endif

>>> src/hcdf_pkg.sv
// ---------------------------------------------------------------------------
// hcdf_pkg
// Sizes, codes and shared types of the 2D inverse-CDF sampler.
// ---------------------------------------------------------------------------
package hcdf_pkg;

  // histogram geometry
  localparam int unsigned MAX_ROWS    = 128;
  localparam int unsigned MAX_COLS    = 128;
  localparam int unsigned WEIGHT_BITS = 16;

  localparam int unsigned ROW_BITS   = $clog2(MAX_ROWS);
  localparam int unsigned COL_BITS   = $clog2(MAX_COLS);
  localparam int unsigned ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int unsigned WT_DEPTH   = 2 ** ADDR_BITS;
  localparam int unsigned RSUM_BITS  = WEIGHT_BITS + COL_BITS;
  localparam int unsigned TOTAL_BITS = RSUM_BITS + ROW_BITS;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PROD_BITS  = TOTAL_BITS + FRAC_BITS;

  // fixed field widths
  localparam int unsigned ROW_FIELD_BITS = 7;
  localparam int unsigned COL_FIELD_BITS = 7;
  localparam int unsigned WFIELD_BITS    = 16;
  localparam int unsigned VALUE_BITS     = 17;
  localparam int unsigned CNT_BITS       = 8;
  localparam int unsigned BASE_BITS      = 16;
  localparam int unsigned STEP_BITS      = 8;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // register reset values
  localparam logic [CNT_BITS-1:0]  RST_ROWS     = 8'd100;
  localparam logic [CNT_BITS-1:0]  RST_COLS     = 8'd120;
  localparam logic [BASE_BITS-1:0] RST_ROW_BASE = 16'd100;
  localparam logic [STEP_BITS-1:0] RST_ROW_STEP = 8'd4;
  localparam logic [BASE_BITS-1:0] RST_COL_BASE = 16'd20;
  localparam logic [STEP_BITS-1:0] RST_COL_STEP = 8'd4;

  // command and result codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam logic RES_ACK    = 1'b0;
  localparam logic RES_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROWS,
    CFG_COLS,
    CFG_ROW_BASE,
    CFG_ROW_STEP,
    CFG_COL_BASE,
    CFG_COL_STEP
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_UPD,
    S_RSUM,
    S_TOT,
    S_MUL_R,
    S_ROW_SCAN,
    S_MUL_C,
    S_COL_SCAN,
    S_DONE
  } state_e;

  // active window, as last valid indices, plus a column-count write strobe
  typedef struct packed {
    logic [ROW_BITS-1:0] rows_last;
    logic [COL_BITS-1:0] cols_last;
    logic                cols_wr;
  } hcdf_cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ROW_BITS-1:0] row_bin;
    logic [COL_BITS-1:0] col_bin;
    logic                empty;
  } hcdf_res_t;

endpackage

>>> src/hcdf_ram.sv
// ---------------------------------------------------------------------------
// hcdf_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module hcdf_ram #(
  parameter  int unsigned Width = 16,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/hcdf_core.sv
// ---------------------------------------------------------------------------
// hcdf_core
// Sequencer and datapath: weight and row-sum memories, scans, compares.
// ---------------------------------------------------------------------------
`include "histogram_2d_inverse_cdf_sampler_macros.svh"

module hcdf_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hcdf_pkg::hcdf_cfg_t                  cfg_i,
  input  logic                                 accept_i,
  input  logic                                 command_i,
  input  logic [hcdf_pkg::ROW_FIELD_BITS-1:0]  cell_row_i,
  input  logic [hcdf_pkg::COL_FIELD_BITS-1:0]  cell_col_i,
  input  logic [hcdf_pkg::WFIELD_BITS-1:0]     cell_weight_i,
  input  logic [hcdf_pkg::FRAC_BITS-1:0]       row_fraction_i,
  input  logic [hcdf_pkg::FRAC_BITS-1:0]       col_fraction_i,
  input  logic                                 out_free_i,
  output logic                                 idle_o,
  output logic                                 done_o,
  output hcdf_pkg::hcdf_res_t                  res_o
);
  import hcdf_pkg::*;

  state_e state_q, state_d;

  logic [ROW_BITS-1:0]    row_cnt_q, row_cnt_d;
  logic [COL_BITS-1:0]    col_cnt_q, col_cnt_d;
  logic                   issue_done_q, issue_done_d;
  logic                   issue;
  logic                   tag_vld_q, tag_last_q, tag_last_d;
  logic [ROW_BITS-1:0]    tag_row_q;
  logic [COL_BITS-1:0]    tag_col_q;
  logic                   dirty_q;

  logic [TOTAL_BITS-1:0]  acc_q, acc_d, acc_sum, scan_data, total_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [RSUM_BITS-1:0]   rsel_q;
  logic [ROW_BITS-1:0]    rbin_q;
  logic [COL_BITS-1:0]    cbin_q;
  logic                   empty_q, kind_q;
  logic [FRAC_BITS-1:0]   frac_r_q, frac_c_q;
  logic [ROW_BITS-1:0]    wr_row_q;
  logic [COL_BITS-1:0]    wr_col_q;
  logic [WEIGHT_BITS-1:0] wr_wt_q;
  logic                   wr_ok_q;

  logic                   row_last, col_last, row_max, col_max;
  logic                   hit, scan_end, tot_end, rs_end, in_range;

  // memory ports
  logic                   wt_we;
  logic [ADDR_BITS-1:0]   wt_waddr, wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;
  logic                   rs_we;
  logic [ROW_BITS-1:0]    rs_waddr, rs_raddr;
  logic [RSUM_BITS-1:0]   rs_wdata, rs_rdata;

  hcdf_ram #(.Width(WEIGHT_BITS), .Depth(WT_DEPTH)) u_wt_ram (
    .clk_i,
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  hcdf_ram #(.Width(RSUM_BITS), .Depth(MAX_ROWS)) u_rs_ram (
    .clk_i,
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  assign row_last = (row_cnt_q == cfg_i.rows_last);
  assign col_last = (col_cnt_q == cfg_i.cols_last);
  assign row_max  = (row_cnt_q == ROW_BITS'(MAX_ROWS - 1));
  assign col_max  = (col_cnt_q == COL_BITS'(MAX_COLS - 1));
  assign in_range = (32'(cell_row_i) < MAX_ROWS) && (32'(cell_col_i) < MAX_COLS);

  // returning read data; row-sum walks use the row-sum RAM
  assign scan_data = ((state_q == S_TOT) || (state_q == S_ROW_SCAN)) ?
                     TOTAL_BITS'(rs_rdata) : TOTAL_BITS'(wt_rdata);
  assign acc_sum   = acc_q + scan_data;
  // cum * 2^16 >= fraction * sum
  assign hit       = ({acc_sum, {FRAC_BITS{1'b0}}} >= prod_q);
  assign scan_end  = tag_vld_q && (tag_last_q || hit);
  assign tot_end   = tag_vld_q && tag_last_q;
  assign rs_end    = tag_vld_q && tag_last_q && (tag_row_q == ROW_BITS'(MAX_ROWS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (row_max && col_max) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept_i) begin
          if (command_i == CMD_WRITE) state_d = S_WR_UPD;
          else if (dirty_q)           state_d = S_RSUM;
          else                        state_d = S_TOT;
        end
      end
      S_WR_UPD:   state_d = S_DONE;
      S_RSUM:     if (rs_end) state_d = S_TOT;
      S_TOT:      if (tot_end) state_d = S_MUL_R;
      S_MUL_R:    state_d = (total_q == '0) ? S_DONE : S_ROW_SCAN;
      S_ROW_SCAN: if (scan_end) state_d = S_MUL_C;
      S_MUL_C:    state_d = (rsel_q == '0) ? S_DONE : S_COL_SCAN;
      S_COL_SCAN: if (scan_end) state_d = S_DONE;
      S_DONE:     if (out_free_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memory control, counters and accumulator
  always_comb begin
    row_cnt_d    = row_cnt_q;
    col_cnt_d    = col_cnt_q;
    issue_done_d = issue_done_q;
    acc_d        = acc_q;
    issue        = 1'b0;
    tag_last_d   = 1'b0;
    wt_we        = 1'b0;
    wt_waddr     = {row_cnt_q, col_cnt_q};
    wt_wdata     = '0;
    wt_raddr     = {row_cnt_q, col_cnt_q};
    rs_we        = 1'b0;
    rs_waddr     = row_cnt_q;
    rs_wdata     = '0;
    rs_raddr     = row_cnt_q;

    unique case (state_q)
      S_CLEAR: begin
        wt_we = 1'b1;
        rs_we = (col_cnt_q == '0);
        if (col_max) begin
          col_cnt_d = '0;
          row_cnt_d = row_cnt_q + 1'b1;
        end else begin
          col_cnt_d = col_cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        wt_raddr = {ROW_BITS'(cell_row_i), COL_BITS'(cell_col_i)};
        rs_raddr = ROW_BITS'(cell_row_i);
      end
      S_WR_UPD: begin
        // swap old weight for new in the row sum
        wt_we    = wr_ok_q;
        wt_waddr = {wr_row_q, wr_col_q};
        wt_wdata = wr_wt_q;
        rs_we    = wr_ok_q && (wr_col_q <= cfg_i.cols_last);
        rs_waddr = wr_row_q;
        rs_wdata = rs_rdata + RSUM_BITS'(wr_wt_q) - RSUM_BITS'(wt_rdata);
      end
      S_RSUM: begin
        issue      = !issue_done_q;
        tag_last_d = col_last;
        if (issue) begin
          if (col_last) begin
            col_cnt_d = '0;
            if (row_max) issue_done_d = 1'b1;
            else         row_cnt_d    = row_cnt_q + 1'b1;
          end else begin
            col_cnt_d = col_cnt_q + 1'b1;
          end
        end
        if (tag_vld_q) begin
          if (tag_last_q) begin
            rs_we    = 1'b1;
            rs_waddr = tag_row_q;
            rs_wdata = RSUM_BITS'(acc_sum);
            acc_d    = '0;
          end else begin
            acc_d = acc_sum;
          end
        end
      end
      S_TOT, S_ROW_SCAN: begin
        issue      = !issue_done_q;
        tag_last_d = row_last;
        if (issue) begin
          if (row_last) issue_done_d = 1'b1;
          else          row_cnt_d    = row_cnt_q + 1'b1;
        end
        if (tag_vld_q) acc_d = acc_sum;
      end
      S_COL_SCAN: begin
        issue      = !issue_done_q;
        tag_last_d = col_last;
        wt_raddr   = {rbin_q, col_cnt_q};
        if (issue) begin
          if (col_last) issue_done_d = 1'b1;
          else          col_cnt_d    = col_cnt_q + 1'b1;
        end
        if (tag_vld_q) acc_d = acc_sum;
      end
      default: begin
      end
    endcase

    // every phase starts from a clean walk
    if (state_d != state_q) begin
      row_cnt_d    = '0;
      col_cnt_d    = '0;
      issue_done_d = 1'b0;
      acc_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      row_cnt_q    <= '0;
      col_cnt_q    <= '0;
      issue_done_q <= 1'b0;
      tag_vld_q    <= 1'b0;
      dirty_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_cnt_q    <= row_cnt_d;
      col_cnt_q    <= col_cnt_d;
      issue_done_q <= issue_done_d;
      tag_vld_q    <= issue;
      // column window changed: row sums are stale until rebuilt
      if (cfg_i.cols_wr) begin
        dirty_q <= 1'b1;
      end else if ((state_q == S_RSUM) && rs_end) begin
        dirty_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_last_q <= tag_last_d;
    tag_row_q  <= row_cnt_q;
    tag_col_q  <= col_cnt_q;
    acc_q      <= acc_d;

    if ((state_q == S_IDLE) && accept_i) begin
      kind_q   <= (command_i == CMD_SAMPLE) ? RES_SAMPLE : RES_ACK;
      rbin_q   <= '0;
      cbin_q   <= '0;
      empty_q  <= 1'b0;
      frac_r_q <= row_fraction_i;
      frac_c_q <= col_fraction_i;
      wr_row_q <= ROW_BITS'(cell_row_i);
      wr_col_q <= COL_BITS'(cell_col_i);
      wr_wt_q  <= WEIGHT_BITS'(cell_weight_i);
      wr_ok_q  <= in_range;
    end

    if ((state_q == S_TOT) && tot_end) begin
      total_q <= acc_sum;
    end

    if (state_q == S_MUL_R) begin
      prod_q <= PROD_BITS'(frac_r_q) * PROD_BITS'(total_q);
      if (total_q == '0) empty_q <= 1'b1;
    end

    if ((state_q == S_ROW_SCAN) && scan_end) begin
      rbin_q <= tag_row_q;
      rsel_q <= rs_rdata;
    end

    if (state_q == S_MUL_C) begin
      prod_q <= PROD_BITS'(frac_c_q) * PROD_BITS'(rsel_q);
      if (rsel_q == '0) empty_q <= 1'b1;
    end

    if ((state_q == S_COL_SCAN) && scan_end) begin
      cbin_q <= tag_col_q;
    end
  end

  assign idle_o        = (state_q == S_IDLE);
  assign done_o        = (state_q == S_DONE) && out_free_i;
  assign res_o.kind    = kind_q;
  assign res_o.row_bin = rbin_q;
  assign res_o.col_bin = cbin_q;
  assign res_o.empty   = empty_q;

  `HCDF_ASSERT_IMP(a_wt_wr_phase, wt_we, (state_q == S_CLEAR) || (state_q == S_WR_UPD))
  `HCDF_ASSERT_IMP(a_row_total, state_q == S_ROW_SCAN, total_q != '0)
  `HCDF_ASSERT_IMP(a_col_rowsum, state_q == S_COL_SCAN, rsel_q != '0)
  `HCDF_ASSERT_IMP(a_dirty_clr, $fell(dirty_q), $past(state_q) == S_RSUM)

endmodule

>>> src/histogram_2d_inverse_cdf_sampler.sv
// ---------------------------------------------------------------------------
// histogram_2d_inverse_cdf_sampler
// 2D weight histogram with discrete inverse-transform sampling.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                  content
//  in       sink       in_valid_i / in_stall_o    command, cell, weight, fractions
//  out      source     out_valid_o / out_stall_i  kind, bins, values, empty flag
//  cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
//  Write request: read old weight and row sum, write both back, present.
//  Sample request: walks over the row-sum RAM (total, then row search) and
//  then over the weight RAM (column search).
//  After a write to the column count (CFG_COLS) the next sample first rebuilds
//  all MAX_ROWS row sums through the weight RAM port.
//  After reset a clearing pass over all MAX_ROWS * MAX_COLS cells (16384)
//  zeroes the memories; in_stall_o is high until it ends.
//  One request at a time; a new request is taken while a result waits in the
//  output register.
// ---------------------------------------------------------------------------
`include "histogram_2d_inverse_cdf_sampler_macros.svh"

module histogram_2d_inverse_cdf_sampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [hcdf_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [hcdf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [hcdf_pkg::ROW_FIELD_BITS-1:0] cell_row_i,
  input  logic [hcdf_pkg::COL_FIELD_BITS-1:0] cell_col_i,
  input  logic [hcdf_pkg::WFIELD_BITS-1:0]    cell_weight_i,
  input  logic [hcdf_pkg::FRAC_BITS-1:0]      row_fraction_i,
  input  logic [hcdf_pkg::FRAC_BITS-1:0]      col_fraction_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                result_kind_o,
  output logic [hcdf_pkg::ROW_FIELD_BITS-1:0] row_bin_o,
  output logic [hcdf_pkg::COL_FIELD_BITS-1:0] col_bin_o,
  output logic [hcdf_pkg::VALUE_BITS-1:0]     row_value_o,
  output logic [hcdf_pkg::VALUE_BITS-1:0]     col_value_o,
  output logic                                empty_flag_o
);
  import hcdf_pkg::*;

  // configuration registers
  logic [CNT_BITS-1:0]  rows_cfg_q, cols_cfg_q;
  logic [BASE_BITS-1:0] row_base_q, col_base_q;
  logic [STEP_BITS-1:0] row_step_q, col_step_q;
  cfg_idx_e             cfg_sel;

  hcdf_cfg_t cfg;
  hcdf_res_t res;
  logic      core_idle, core_done, accept, out_free;

  logic                      out_valid_q;
  logic                      out_kind_q, out_empty_q;
  logic [ROW_FIELD_BITS-1:0] out_row_bin_q;
  logic [COL_FIELD_BITS-1:0] out_col_bin_q;
  logic [VALUE_BITS-1:0]     out_row_value_q, out_col_value_q;
  logic [ROW_FIELD_BITS-1:0] rbin;
  logic [COL_FIELD_BITS-1:0] cbin;

  assign cfg_sel = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= RST_ROWS;
      cols_cfg_q <= RST_COLS;
      row_base_q <= RST_ROW_BASE;
      row_step_q <= RST_ROW_STEP;
      col_base_q <= RST_COL_BASE;
      col_step_q <= RST_COL_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        CFG_ROWS:     rows_cfg_q <= CNT_BITS'(cfg_wdata_i);
        CFG_COLS:     cols_cfg_q <= CNT_BITS'(cfg_wdata_i);
        CFG_ROW_BASE: row_base_q <= BASE_BITS'(cfg_wdata_i);
        CFG_ROW_STEP: row_step_q <= STEP_BITS'(cfg_wdata_i);
        CFG_COL_BASE: col_base_q <= BASE_BITS'(cfg_wdata_i);
        CFG_COL_STEP: col_step_q <= STEP_BITS'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // active window as last index: zero acts as one, oversize saturates
  always_comb begin
    if (rows_cfg_q == '0) begin
      cfg.rows_last = '0;
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      cfg.rows_last = ROW_BITS'(MAX_ROWS - 1);
    end else begin
      cfg.rows_last = ROW_BITS'(rows_cfg_q - 1'b1);
    end
    if (cols_cfg_q == '0) begin
      cfg.cols_last = '0;
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      cfg.cols_last = COL_BITS'(MAX_COLS - 1);
    end else begin
      cfg.cols_last = COL_BITS'(cols_cfg_q - 1'b1);
    end
    cfg.cols_wr = cfg_we_i && (cfg_sel == CFG_COLS);
  end

  assign accept     = in_valid_i && core_idle;
  assign in_stall_o = !core_idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  hcdf_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg),
    .accept_i       (accept),
    .command_i,
    .cell_row_i,
    .cell_col_i,
    .cell_weight_i,
    .row_fraction_i,
    .col_fraction_i,
    .out_free_i     (out_free),
    .idle_o         (core_idle),
    .done_o         (core_done),
    .res_o          (res)
  );

  assign rbin = ROW_FIELD_BITS'(res.row_bin);
  assign cbin = COL_FIELD_BITS'(res.col_bin);

  // output register; value mapping is applied on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_kind_q    <= res.kind;
      out_row_bin_q <= rbin;
      out_col_bin_q <= cbin;
      out_empty_q   <= res.empty;
      if (res.kind == RES_SAMPLE) begin
        out_row_value_q <= VALUE_BITS'(row_base_q)
                         + VALUE_BITS'(rbin) * VALUE_BITS'(row_step_q);
        out_col_value_q <= VALUE_BITS'(col_base_q)
                         + VALUE_BITS'(cbin) * VALUE_BITS'(col_step_q);
      end else begin
        out_row_value_q <= '0;
        out_col_value_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign row_bin_o     = out_row_bin_q;
  assign col_bin_o     = out_col_bin_q;
  assign row_value_o   = out_row_value_q;
  assign col_value_o   = out_col_value_q;
  assign empty_flag_o  = out_empty_q;

  `HCDF_ASSERT_IMP(a_load_free, core_done, !out_valid_q || !out_stall_i)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: 2D inverse-CDF sampler
// Drives write and sample requests with random gaps, mirrors the weight
// histogram and the register file, and checks every result in order.
// ---------------------------------------------------------------------------
module testbench;
  import hcdf_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 80000;  // clear pass or row-sum rebuild, hold-off, slack
  localparam int unsigned HOLD_CYCLES = 2500;
  localparam int unsigned DRAIN_WAIT  = 500;    // longer than any sample without a rebuild

  typedef struct packed {
    logic                      command;
    logic [ROW_FIELD_BITS-1:0] cell_row;
    logic [COL_FIELD_BITS-1:0] cell_col;
    logic [WFIELD_BITS-1:0]    cell_weight;
    logic [FRAC_BITS-1:0]      row_fraction;
    logic [FRAC_BITS-1:0]      col_fraction;
  } hist_req_t;

  typedef struct packed {
    logic                      kind;
    logic [ROW_FIELD_BITS-1:0] row_bin;
    logic [COL_FIELD_BITS-1:0] col_bin;
    logic [VALUE_BITS-1:0]     row_value;
    logic [VALUE_BITS-1:0]     col_value;
    logic                      empty;
  } hist_res_t;

  // DUT connections, inputs known from time zero
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i      = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i    = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic                      command_i      = 1'b0;
  logic [ROW_FIELD_BITS-1:0] cell_row_i     = '0;
  logic [COL_FIELD_BITS-1:0] cell_col_i     = '0;
  logic [WFIELD_BITS-1:0]    cell_weight_i  = '0;
  logic [FRAC_BITS-1:0]      row_fraction_i = '0;
  logic [FRAC_BITS-1:0]      col_fraction_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic                      result_kind_o;
  logic [ROW_FIELD_BITS-1:0] row_bin_o;
  logic [COL_FIELD_BITS-1:0] col_bin_o;
  logic [VALUE_BITS-1:0]     row_value_o;
  logic [VALUE_BITS-1:0]     col_value_o;
  logic                      empty_flag_o;

  // mirror of the histogram and of the register file
  logic [WFIELD_BITS-1:0] weight_mirror [MAX_ROWS][MAX_COLS];
  logic [CNT_BITS-1:0]    rows_reg     = RST_ROWS;
  logic [CNT_BITS-1:0]    cols_reg     = RST_COLS;
  logic [BASE_BITS-1:0]   row_base_reg = RST_ROW_BASE;
  logic [STEP_BITS-1:0]   row_step_reg = RST_ROW_STEP;
  logic [BASE_BITS-1:0]   col_base_reg = RST_COL_BASE;
  logic [STEP_BITS-1:0]   col_step_reg = RST_COL_STEP;

  hist_req_t   request_backlog [$];  // requests not yet offered
  hist_res_t   outcome_due [$];      // predicted results, oldest first
  hist_req_t   held_req;             // request currently on the input port
  hist_res_t   seen_res, want_res;
  bit          steady       = 1'b0;  // no gaps on either side while set
  int unsigned hold_orders  = 0;     // hold-offs asked for by the sequencer
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;

  histogram_2d_inverse_cdf_sampler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .cell_weight_i  (cell_weight_i),
    .row_fraction_i (row_fraction_i),
    .col_fraction_i (col_fraction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .row_bin_o      (row_bin_o),
    .col_bin_o      (col_bin_o),
    .row_value_o    (row_value_o),
    .col_value_o    (col_value_o),
    .empty_flag_o   (empty_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (weight_mirror[r, c]) weight_mirror[r][c] = '0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 0 behaves as 1, anything past the table size as the table size
  function automatic int unsigned clamp_span(logic [CNT_BITS-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // cum/total >= frac/65536, cross-multiplied; 46 bits at most either side
  function automatic bit share_met(longint unsigned cum, longint unsigned frac,
                                   longint unsigned total);
    return (cum << 16) >= (total * frac);
  endfunction

  // Applies one request to the mirror and returns the result it must produce.
  function automatic hist_res_t sampler_outcome(hist_req_t rq);
    hist_res_t       res;
    longint unsigned line_sum [MAX_ROWS];
    longint unsigned total, cum, picked_sum;
    int unsigned     n_rows, n_cols, rb, cb;
    bit              found;
    res = '0;
    // 7-bit cell indices always land inside a 128 x 128 table
    if (rq.command == CMD_WRITE) begin
      weight_mirror[rq.cell_row][rq.cell_col] = rq.cell_weight;
      res.kind = RES_ACK;
      return res;
    end
    n_rows = clamp_span(rows_reg, MAX_ROWS);
    n_cols = clamp_span(cols_reg, MAX_COLS);
    total  = 0;
    for (int r = 0; r < n_rows; r++) begin
      line_sum[r] = 0;
      for (int c = 0; c < n_cols; c++) line_sum[r] += weight_mirror[r][c];
      total += line_sum[r];
    end
    rb = 0;
    cb = 0;
    if (total == 0) begin
      res.empty = 1'b1;
    end else begin
      // the search settles on the last active bin if nothing qualifies first
      rb    = n_rows - 1;
      cum   = 0;
      found = 1'b0;
      for (int r = 0; r < n_rows && !found; r++) begin
        cum += line_sum[r];
        if (share_met(cum, rq.row_fraction, total)) begin
          rb    = r;
          found = 1'b1;
        end
      end
      picked_sum = line_sum[rb];
      if (picked_sum == 0) begin
        // fraction 0 can stop on a leading empty row
        res.empty = 1'b1;
      end else begin
        cb    = n_cols - 1;
        cum   = 0;
        found = 1'b0;
        for (int c = 0; c < n_cols && !found; c++) begin
          cum += weight_mirror[rb][c];
          if (share_met(cum, rq.col_fraction, picked_sum)) begin
            cb    = c;
            found = 1'b1;
          end
        end
      end
    end
    res.kind      = RES_SAMPLE;
    res.row_bin   = ROW_FIELD_BITS'(rb);
    res.col_bin   = COL_FIELD_BITS'(cb);
    res.row_value = VALUE_BITS'(row_base_reg + rb * row_step_reg);
    res.col_value = VALUE_BITS'(col_base_reg + cb * col_step_reg);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // unused fields carry random bits so every input bit toggles
  function automatic hist_req_t write_req(int unsigned row, int unsigned col,
                                          int unsigned weight);
    hist_req_t rq;
    rq.command      = CMD_WRITE;
    rq.cell_row     = ROW_FIELD_BITS'(row);
    rq.cell_col     = COL_FIELD_BITS'(col);
    rq.cell_weight  = WFIELD_BITS'(weight);
    rq.row_fraction = FRAC_BITS'($urandom);
    rq.col_fraction = FRAC_BITS'($urandom);
    return rq;
  endfunction

  function automatic hist_req_t sample_req(int unsigned fr, int unsigned fc);
    hist_req_t rq;
    rq.command      = CMD_SAMPLE;
    rq.cell_row     = ROW_FIELD_BITS'($urandom);
    rq.cell_col     = COL_FIELD_BITS'($urandom);
    rq.cell_weight  = WFIELD_BITS'($urandom);
    rq.row_fraction = FRAC_BITS'(fr);
    rq.col_fraction = FRAC_BITS'(fc);
    return rq;
  endfunction

  function automatic int unsigned pick_fraction();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  // Half are writes, mostly into the active window so samples meet a populated histogram;
  // row and column of a write are each drawn from the whole table about one time in four.
  function automatic hist_req_t random_request();
    int unsigned n_rows, n_cols, row, col, weight;
    n_rows = clamp_span(rows_reg, MAX_ROWS);
    n_cols = clamp_span(cols_reg, MAX_COLS);
    if ($urandom_range(99) < 50) begin
      row = ($urandom_range(3) == 0) ? $urandom_range(MAX_ROWS - 1) : $urandom_range(n_rows - 1);
      col = ($urandom_range(3) == 0) ? $urandom_range(MAX_COLS - 1) : $urandom_range(n_cols - 1);
      case ($urandom_range(9))
        0, 1:    weight = 0;        // clears cells, so empty rows turn up
        2:       weight = 16'hFFFF;
        3, 4:    weight = $urandom_range(15);
        default: weight = $urandom_range(16'hFFFF);
      endcase
      return write_req(row, col, weight);
    end
    return sample_req(pick_fraction(), pick_fraction());
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------

  // appends one request behind those still waiting
  function automatic void add_request(hist_req_t rq);
    request_backlog.insert(request_backlog.size(), rq);
  endfunction

  task automatic set_register(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_ROWS:     rows_reg     = data[CNT_BITS-1:0];
      CFG_COLS:     cols_reg     = data[CNT_BITS-1:0];
      CFG_ROW_BASE: row_base_reg = data[BASE_BITS-1:0];
      CFG_ROW_STEP: row_step_reg = data[STEP_BITS-1:0];
      CFG_COL_BASE: col_base_reg = data[BASE_BITS-1:0];
      CFG_COL_STEP: col_step_reg = data[STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  // all six registers, then the write enable drops on the following edge
  task automatic configure(input logic [CFG_DATA_BITS-1:0] rows, cols,
                           rbase, rstep, cbase, cstep);
    set_register(CFG_ROWS, rows);
    set_register(CFG_COLS, cols);
    set_register(CFG_ROW_BASE, rbase);
    set_register(CFG_ROW_STEP, rstep);
    set_register(CFG_COL_BASE, cbase);
    set_register(CFG_COL_STEP, cstep);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) add_request(random_request());
  endtask

  // every request offered and accepted, every result returned
  task automatic settle();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || in_valid_i || outcome_due.size() != 0);
  endtask

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the reset window (100 rows, 120 columns).
    add_request(sample_req(0, 0));              // empty histogram
    add_request(sample_req(16'hFFFF, 16'hFFFF));
    add_request(write_req(0, 0, 16'hFFFF));
    add_request(write_req(99, 119, 16'hFFFF));  // last active cell
    add_request(write_req(127, 127, 16'hFFFF)); // outside the window
    add_request(write_req(100, 0, 1234));       // row just past it
    add_request(sample_req(0, 0));
    add_request(sample_req(16'hFFFF, 16'hFFFF)); // last row and column
    add_request(sample_req(16'h8000, 0));        // share exactly reached
    add_request(sample_req(16'h8001, 16'hFFFF)); // one step past it
    add_request(write_req(0, 0, 0));
    add_request(sample_req(0, 16'h8000));        // lands on an empty row
    add_request(write_req(42, 85, 16'hAAAA));
    add_request(write_req(85, 42, 16'h5555));
    add_request(write_req(64, 64, 1));
    add_request(sample_req(16'h5555, 16'hAAAA));
    add_request(sample_req(16'hAAAA, 16'h5555));
    add_request(write_req(99, 0, 16'hFFFF));
    add_request(sample_req(16'hFFFF, 0));
    add_request(sample_req(16'hFFFF, 16'h8000));
    settle();

    // Reset window, random mix; the receiver holds off once so the block backs up.
    queue_random(150);
    hold_orders++;
    settle();

    // smallest window, values fixed at the base
    configure(1, 1, 0, 0, 0, 0);
    queue_random(100);
    settle();

    // full table, largest base and step
    configure(MAX_ROWS, MAX_COLS, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    queue_random(100);
    settle();

    // zero sizes act as one
    configure(0, 0, $urandom_range(16'hFFFF), $urandom_range(255),
              $urandom_range(16'hFFFF), $urandom_range(255));
    queue_random(80);
    settle();

    // oversized counts clamp to the table; upper data bits are dropped
    configure(16'hFFFF, 16'hFF90, $urandom_range(16'hFFFF), 16'h5A00 | $urandom_range(255),
              $urandom_range(16'hFFFF), 16'hA500 | $urandom_range(255));
    queue_random(60);
    settle();

    // tiny window, back to back with no gaps on either side
    steady = 1'b1;
    configure(2, 3, $urandom_range(16'hFFFF), $urandom_range(255),
              $urandom_range(16'hFFFF), $urandom_range(255));
    queue_random(120);
    settle();
    steady = 1'b0;

    // small random windows
    configure($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    queue_random(150);
    settle();

    // anything within range
    configure($urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(16'hFFFF),
              $urandom_range(255), $urandom_range(16'hFFFF), $urandom_range(255));
    queue_random(100);
    settle();

    // catch any stray result after the last one
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fault_count == 0 && outcome_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one request on the port at a time, held until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        outcome_due.insert(outcome_due.size(), sampler_outcome(held_req));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_backlog.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          held_req = request_backlog.pop_front();
          in_valid_i     <= 1'b1;
          command_i      <= held_req.command;
          cell_row_i     <= held_req.cell_row;
          cell_col_i     <= held_req.cell_col;
          cell_weight_i  <= held_req.cell_weight;
          row_fraction_i <= held_req.row_fraction;
          col_fraction_i <= held_req.col_fraction;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results in order and drives the result-side stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_res.kind      = result_kind_o;
        seen_res.row_bin   = row_bin_o;
        seen_res.col_bin   = col_bin_o;
        seen_res.row_value = row_value_o;
        seen_res.col_value = col_value_o;
        seen_res.empty     = empty_flag_o;
        if (outcome_due.size() == 0) begin
          note_fault($sformatf("unrequested result at %0t: kind %0d row_bin %0d col_bin %0d",
                               $realtime, result_kind_o, row_bin_o, col_bin_o));
        end else begin
          want_res = outcome_due.pop_front();
          if (seen_res !== want_res) begin
            note_fault($sformatf({"result mismatch at %0t: expected kind %0d row_bin %0d ",
                                  "col_bin %0d row_value %0d col_value %0d empty %0d, got ",
                                  "kind %0d row_bin %0d col_bin %0d row_value %0d ",
                                  "col_value %0d empty %0d"},
                                 $realtime, want_res.kind, want_res.row_bin,
                                 want_res.col_bin, want_res.row_value, want_res.col_value,
                                 want_res.empty, seen_res.kind, seen_res.row_bin,
                                 seen_res.col_bin, seen_res.row_value, seen_res.col_value,
                                 seen_res.empty));
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_served != hold_orders) begin
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 34);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when neither channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
